// ===== sv/htsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htsu_pkg
// Shared types and constants of the six-bit Huffman tree unpacker.
// ----------------------------------------------------------------------------
package htsu_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NODE_W  = 7;
	localparam int unsigned SYM_W   = 6;
	localparam int unsigned TERM_B  = 7;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [1:0] HELD_FULL = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] table_index;
		logic [BYTE_W-1:0] table_entry;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
	} out_item_t;

endpackage
`default_nettype wire

// ===== sv/htsu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htsu channel interfaces
// Valid/ready channels for input items and decoded result bytes.
// ----------------------------------------------------------------------------
interface htsu_item_if;
	logic               valid;
	logic               ready;
	htsu_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface htsu_result_if;
	logic                valid;
	logic                ready;
	htsu_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/huffman_tree_six_bit_unpacker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_six_bit_unpacker_unit
// Walks a loaded Huffman tree table bit by bit and packs six-bit symbols
// four at a time into three output bytes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  item      in   valid/ready    kind, table_index, table_entry, data_byte
//  result    out  valid/ready    out_byte, last_of_run
//  cfg       in   cfg_we         cfg_wdata -> bypass
//
//  table write: written when accepted. coded byte: the accepting cycle and
//  the walk, one tree table read per bit, each address taken from the
//  previous read. then one result byte per cycle, stalled by result ready,
//  up to six. bypass byte: accepted and passed out as one result.
//  reset clears walk state and bypass; the tree table keeps its contents.
//  item ready stays low while a byte is walked or results wait to be taken.
// ----------------------------------------------------------------------------
module huffman_tree_six_bit_unpacker_unit #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	htsu_item_if.sink        item,
	htsu_result_if.source    result
);

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned BW     = htsu_pkg::BYTE_W;
	localparam int unsigned NW     = htsu_pkg::NODE_W;
	localparam int unsigned SW     = htsu_pkg::SYM_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t          state_q;
	logic            bypass_q;
	logic [NW-1:0]   node_q;
	logic [1:0]      held_cnt_q;
	logic [SW-1:0]   held_q [3];
	logic [NW-1:0]   sh_q;
	logic [2:0]      rem_q;
	logic [BW-1:0]   buf_q [6];
	logic [2:0]      buf_cnt_q;
	logic [2:0]      ptr_q;
	logic            grp_q;

	logic [BW-1:0]   mem [TABLE_DEPTH];
	logic [BW-1:0]   rd_data_s1;
	logic            rd_oob_s1;

	logic            in_acc;
	logic            out_acc;
	logic            rd_en;
	logic [BW-1:0]   rd_addr;
	logic            rd_in_range;
	logic            wr_en;
	logic [BW-1:0]   entry;
	logic [SW-1:0]   sym;
	logic [NW-1:0]   node_nxt;
	logic            emit;
	logic [2:0]      cnt_nxt;
	logic            is_last;

	assign in_acc  = item.valid && item.ready;
	assign out_acc = result.valid && result.ready;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = (state_q == ST_DRAIN);

	assign is_last = (ptr_q == buf_cnt_q - 3'd1);
	assign result.data.out_byte    = buf_q[ptr_q];
	assign result.data.last_of_run = is_last;

	// walk step on the registered table read
	assign entry    = rd_oob_s1 ? '0 : rd_data_s1;
	assign sym      = entry[SW-1:0];
	assign node_nxt = entry[htsu_pkg::TERM_B] ? '0 : entry[NW-1:0];
	assign emit     = entry[htsu_pkg::TERM_B] && (held_cnt_q == htsu_pkg::HELD_FULL);
	assign cnt_nxt  = emit ? buf_cnt_q + 3'd3 : buf_cnt_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {node_q, ~item.data.data_byte[BW-1]};
		if (state_q == ST_IDLE) begin
			rd_en = in_acc && (item.data.kind == htsu_pkg::KIND_DATA) && !bypass_q;
		end else if (state_q == ST_WALK) begin
			rd_en   = (rem_q != 3'd0);
			rd_addr = {node_nxt, ~sh_q[NW-1]};
		end
	end

	assign rd_in_range = ({1'b0, rd_addr} < 9'(TABLE_DEPTH));
	assign wr_en = in_acc && (item.data.kind == htsu_pkg::KIND_TABLE)
		&& ({1'b0, item.data.table_index} < 9'(TABLE_DEPTH));

	// tree table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item.data.table_index[ADDR_W-1:0]] <= item.data.table_entry;
		end
		if (rd_en && rd_in_range) begin
			rd_data_s1 <= mem[rd_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_s1 <= 1'b0;
		end else if (rd_en) begin
			rd_oob_s1 <= !rd_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			bypass_q <= cfg_wdata;
		end
	end

	// result bytes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && item.data.kind == htsu_pkg::KIND_DATA) begin
			buf_q[0] <= item.data.data_byte;
		end else if (state_q == ST_WALK && emit) begin
			if (grp_q) begin
				buf_q[3] <= {sym[5:4], held_q[0]};
				buf_q[4] <= {sym[3:2], held_q[1]};
				buf_q[5] <= {sym[1:0], held_q[2]};
			end else begin
				buf_q[0] <= {sym[5:4], held_q[0]};
				buf_q[1] <= {sym[3:2], held_q[1]};
				buf_q[2] <= {sym[1:0], held_q[2]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			node_q     <= '0;
			held_cnt_q <= '0;
			held_q[0]  <= '0;
			held_q[1]  <= '0;
			held_q[2]  <= '0;
			sh_q       <= '0;
			rem_q      <= '0;
			buf_cnt_q  <= '0;
			ptr_q      <= '0;
			grp_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && item.data.kind == htsu_pkg::KIND_DATA) begin
						ptr_q <= '0;
						grp_q <= 1'b0;
						if (bypass_q) begin
							buf_cnt_q <= 3'd1;
							state_q   <= ST_DRAIN;
						end else begin
							buf_cnt_q <= '0;
							sh_q      <= item.data.data_byte[NW-1:0];
							rem_q     <= 3'd7;
							state_q   <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					node_q <= node_nxt;
					if (entry[htsu_pkg::TERM_B]) begin
						if (emit) begin
							held_cnt_q <= '0;
							grp_q      <= 1'b1;
						end else begin
							held_q[held_cnt_q] <= sym;
							held_cnt_q         <= held_cnt_q + 2'd1;
						end
					end
					buf_cnt_q <= cnt_nxt;
					if (rem_q != 3'd0) begin
						rem_q <= rem_q - 3'd1;
						sh_q  <= {sh_q[NW-2:0], 1'b0};
					end else if (cnt_nxt != 3'd0) begin
						state_q <= ST_DRAIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					if (out_acc) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/htsu_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htsu_checker
// Port-level checks of the six-bit Huffman tree unpacker, bound to the top.
// ----------------------------------------------------------------------------
module htsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_kind,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("result changed while stalled");

	// a coded byte occupies the block
	a_busy_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == htsu_pkg::KIND_DATA) |=> !in_ready)
		else $error("item taken while a coded byte is in flight");

	// no new item while results wait
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item side open while results pending");

	// the final byte closes the run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid && in_ready)
		else $error("results continue after last byte");

endmodule

bind huffman_tree_six_bit_unpacker_unit htsu_checker u_htsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_kind   (item.data.kind),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.data.out_byte),
	.out_last  (result.data.last_of_run)
);
`default_nettype wire
